/* hdl/neighbourhood_hash_map_with_overflow_unit_macros.svh */
// Assertion macros for the hash map unit
`ifndef NEIGHBOURHOOD_HASH_MAP_WITH_OVERFLOW_UNIT_MACROS_SVH
`define NEIGHBOURHOOD_HASH_MAP_WITH_OVERFLOW_UNIT_MACROS_SVH

// Implication checked on every rising clock edge while out of reset
`define NHM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked while out of reset
`define NHM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/nhm_pkg.sv */
// Package: constants, types and opcodes of the hash map unit
package nhm_pkg;

    localparam int TABLE_SLOTS      = 64;
    localparam int EXTRA_NEIGHBOURS = 3;
    localparam int BUCKET_DEPTH     = 4;
    localparam int WORD_BITS        = 32;
    localparam int SLOT_BITS        = $clog2(TABLE_SLOTS);
    localparam int BPOS_BITS        = $clog2(BUCKET_DEPTH);
    localparam int FILL_BITS        = $clog2(BUCKET_DEPTH + 1);
    localparam int PROBES           = EXTRA_NEIGHBOURS + 1;
    localparam int PROBE_BITS       = $clog2(PROBES + 1);
    localparam int COUNT_BITS       = 9;
    localparam int SIZE_BITS        = 7;
    localparam int HASH_BITS        = 32;
    localparam logic [SIZE_BITS-1:0] SIZE_RESET = 7'd53;
    localparam logic [SIZE_BITS-1:0] SIZE_FLOOR = 7'd4;

    typedef enum logic [1:0] {
        OP_FIND   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2,
        ST_SPARE   = 2'd3
    } status_t;

    // Home slot computation request/result
    typedef struct packed {
        logic                  start;
        logic [HASH_BITS-1:0]  hash;
        logic [SIZE_BITS-1:0]  size;
    } mod_req_t;

    typedef struct packed {
        logic                  done;
        logic [SLOT_BITS-1:0]  home;
    } mod_rsp_t;

endpackage

/* hdl/nhm_mod.sv */
// Iterative restoring modulo of the hash code by the table size
module nhm_mod
    import nhm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mod_req_t req,
    output mod_rsp_t rsp
);

    localparam int STEP_BITS = $clog2(HASH_BITS + 1);

    logic [HASH_BITS-1:0] quo_reg, quo_next;
    logic [SIZE_BITS:0]   rem_reg, rem_next;
    logic [SIZE_BITS-1:0] div_reg, div_next;
    logic [STEP_BITS-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [SIZE_BITS+1:0] shifted;

    // One quotient bit per cycle
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[HASH_BITS-1]};
        if (req.start)
        begin
            quo_next  = req.hash;
            rem_next  = '0;
            div_next  = req.size;
            cnt_next  = STEP_BITS'(HASH_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[HASH_BITS-2:0], 1'b0};
            if (shifted >= {2'b00, div_reg})
                rem_next = (SIZE_BITS+1)'(shifted - {2'b00, div_reg});
            else
                rem_next = (SIZE_BITS+1)'(shifted);
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done = done_reg;
    assign rsp.home = rem_reg[SLOT_BITS-1:0];

endmodule

/* hdl/neighbourhood_hash_map_with_overflow_unit.sv */
// Top level: hash map engine with neighbourhood probing and overflow buckets
//
//  channel | handshake                 | payload
//  --------+---------------------------+--------------------------------------------
//  in      | in_valid / in_stall       | op, key, value, hash_code
//  out     | out_valid / out_stall     | status, hit, found_value, in_overflow,
//          |                           | entry_total
//  cfg     | cfg_we                    | cfg_data (table_size_in_use)
//
// One request at a time: out_valid rises after the accept once the request has passed the
// bit-serial modulo, a read and a check per probe and per bucket entry, a final read that
// ends the walk, a read and a move for a bucket removal, and the action step.
// Reset clears occupancy flags and bucket fill counts at once (flip-flops); no sweep.
// A result waits in the output register while out_stall is high; the next request is
// accepted in the cycle after the result has left.
module neighbourhood_hash_map_with_overflow_unit
    import nhm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [SIZE_BITS-1:0]  cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            op,
    input  logic [WORD_BITS-1:0]  key,
    input  logic [WORD_BITS-1:0]  value,
    input  logic [HASH_BITS-1:0]  hash_code,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic                  hit,
    output logic [WORD_BITS-1:0]  found_value,
    output logic                  in_overflow,
    output logic [COUNT_BITS-1:0] entry_total
);

`include "neighbourhood_hash_map_with_overflow_unit_macros.svh"

    localparam int BADDR_BITS = SLOT_BITS + BPOS_BITS;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MOD   = 10'b0000000010,
        S_SRD   = 10'b0000000100,
        S_SCHK  = 10'b0000001000,
        S_BRD   = 10'b0000010000,
        S_BCHK  = 10'b0000100000,
        S_LRD   = 10'b0001000000,
        S_LMOV  = 10'b0010000000,
        S_ACT   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration register
    logic [SIZE_BITS-1:0] size_cfg_reg;
    logic [SIZE_BITS-1:0] size_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_cfg_reg <= SIZE_RESET;
        else if (cfg_we)
            size_cfg_reg <= cfg_data;
    end

    always_comb
    begin
        size_eff = size_cfg_reg;
        if (size_cfg_reg < SIZE_FLOOR)
            size_eff = SIZE_FLOOR;
        else if (size_cfg_reg > SIZE_BITS'(TABLE_SLOTS))
            size_eff = SIZE_BITS'(TABLE_SLOTS);
    end

    // Request registers
    op_t                  op_reg;
    logic [WORD_BITS-1:0] key_reg, val_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic [SLOT_BITS-1:0] home_reg;

    // Search state
    logic [SLOT_BITS-1:0]  ptr_reg, ptr_next;
    logic [PROBE_BITS-1:0] pcnt_reg, pcnt_next;
    logic                  mfound_reg, mfound_next;
    logic [SLOT_BITS-1:0]  mslot_reg, mslot_next;
    logic                  free_ok_reg, free_ok_next;
    logic [SLOT_BITS-1:0]  free_slot_reg, free_slot_next;
    logic [FILL_BITS-1:0]  bidx_reg, bidx_next;
    logic                  bfound_reg, bfound_next;
    logic [BPOS_BITS-1:0]  bpos_reg, bpos_next;
    logic [WORD_BITS-1:0]  fval_reg, fval_next;

    // Bookkeeping in flip-flops
    logic [TABLE_SLOTS-1:0] occ_reg;
    logic [FILL_BITS-1:0]   fill_reg [TABLE_SLOTS];
    logic [COUNT_BITS-1:0]  count_reg;

    // Result register
    logic                  out_valid_reg;
    status_t               status_reg;
    logic                  hit_reg, ovf_reg;
    logic [WORD_BITS-1:0]  fv_reg;

    // Modulo unit
    mod_req_t mreq;
    mod_rsp_t mrsp;

    nhm_mod u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    logic in_acc;
    assign in_acc = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    assign mreq.start = in_acc;
    assign mreq.hash  = hash_code;
    assign mreq.size  = size_eff;

    // Slot memory: key and value, one read port, one write port
    logic [2*WORD_BITS-1:0] slot_mem [TABLE_SLOTS];
    logic [2*WORD_BITS-1:0] slot_rd_reg;
    logic                   slot_we;
    logic [SLOT_BITS-1:0]   slot_wa;
    logic [2*WORD_BITS-1:0] slot_wd;

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_wa] <= slot_wd;
        slot_rd_reg <= slot_mem[ptr_reg];
    end

    // Bucket memory
    logic [2*WORD_BITS-1:0] bkt_mem [TABLE_SLOTS*BUCKET_DEPTH];
    logic [2*WORD_BITS-1:0] bkt_rd_reg;
    logic                   bkt_we;
    logic [BADDR_BITS-1:0]  bkt_wa;
    logic [2*WORD_BITS-1:0] bkt_wd;
    logic [BADDR_BITS-1:0]  bkt_ra;

    always_ff @(posedge clk)
    begin
        if (bkt_we)
            bkt_mem[bkt_wa] <= bkt_wd;
        bkt_rd_reg <= bkt_mem[bkt_ra];
    end

    logic [FILL_BITS-1:0] home_fill;
    logic [FILL_BITS-1:0] last_idx;
    assign home_fill = fill_reg[home_reg];
    assign last_idx  = home_fill - 1'b1;

    always_comb
    begin
        bkt_ra = {home_reg, bidx_reg[BPOS_BITS-1:0]};
        if (state_reg == S_LRD)
            bkt_ra = {home_reg, last_idx[BPOS_BITS-1:0]};
    end

    logic [SLOT_BITS-1:0] ptr_inc;
    always_comb
    begin
        ptr_inc = ptr_reg + 1'b1;
        if ({1'b0, ptr_reg} + 1'b1 >= size_reg)
            ptr_inc = '0;
    end

    logic do_op;
    assign do_op = (op_reg != OP_NONE);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        pcnt_next      = pcnt_reg;
        mfound_next    = mfound_reg;
        mslot_next     = mslot_reg;
        free_ok_next   = free_ok_reg;
        free_slot_next = free_slot_reg;
        bidx_next      = bidx_reg;
        bfound_next    = bfound_reg;
        bpos_next      = bpos_reg;
        fval_next      = fval_reg;
        slot_we = 1'b0;
        slot_wa = mslot_reg;
        slot_wd = {key_reg, val_reg};
        bkt_we  = 1'b0;
        bkt_wa  = {home_reg, bpos_reg};
        bkt_wd  = bkt_rd_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                    state_next = S_MOD;
            end
            S_MOD:
            begin
                if (mrsp.done)
                begin
                    ptr_next     = mrsp.home;
                    pcnt_next    = '0;
                    mfound_next  = 1'b0;
                    free_ok_next = 1'b0;
                    bidx_next    = '0;
                    bfound_next  = 1'b0;
                    fval_next    = '0;
                    state_next   = do_op ? S_SRD : S_ACT;
                end
            end
            S_SRD:
                state_next = S_SCHK;
            S_SCHK:
            begin
                if (occ_reg[ptr_reg] && slot_rd_reg[2*WORD_BITS-1:WORD_BITS] == key_reg)
                begin
                    mfound_next = 1'b1;
                    mslot_next  = ptr_reg;
                    fval_next   = slot_rd_reg[WORD_BITS-1:0];
                    state_next  = S_ACT;
                end
                else
                begin
                    if (!occ_reg[ptr_reg] && !free_ok_reg)
                    begin
                        free_ok_next   = 1'b1;
                        free_slot_next = ptr_reg;
                    end
                    ptr_next  = ptr_inc;
                    pcnt_next = pcnt_reg + 1'b1;
                    if (pcnt_reg == PROBE_BITS'(PROBES - 1))
                        state_next = S_BRD;
                    else
                        state_next = S_SRD;
                end
            end
            S_BRD:
            begin
                if (bidx_reg >= home_fill)
                    state_next = S_ACT;
                else
                    state_next = S_BCHK;
            end
            S_BCHK:
            begin
                if (bkt_rd_reg[2*WORD_BITS-1:WORD_BITS] == key_reg)
                begin
                    bfound_next = 1'b1;
                    bpos_next   = bidx_reg[BPOS_BITS-1:0];
                    fval_next   = bkt_rd_reg[WORD_BITS-1:0];
                    state_next  = (op_reg == OP_REMOVE) ? S_LRD : S_ACT;
                end
                else
                begin
                    bidx_next  = bidx_reg + 1'b1;
                    state_next = S_BRD;
                end
            end
            S_LRD:
                state_next = S_LMOV;
            S_LMOV:
            begin
                // move last bucket entry into the gap
                bkt_we     = 1'b1;
                state_next = S_ACT;
            end
            S_ACT:
            begin
                if (op_reg == OP_INSERT)
                begin
                    if (mfound_reg)
                    begin
                        slot_we = 1'b1;
                    end
                    else if (bfound_reg)
                    begin
                        bkt_we = 1'b1;
                        bkt_wd = {key_reg, val_reg};
                    end
                    else if (free_ok_reg)
                    begin
                        slot_we = 1'b1;
                        slot_wa = free_slot_reg;
                    end
                    else if (home_fill < FILL_BITS'(BUCKET_DEPTH))
                    begin
                        bkt_we = 1'b1;
                        bkt_wa = {home_reg, home_fill[BPOS_BITS-1:0]};
                        bkt_wd = {key_reg, val_reg};
                    end
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Result and bookkeeping update at the action step
    status_t              st_a;
    logic                 hit_a, ovf_a;
    logic [WORD_BITS-1:0] fv_a;
    logic                 occ_set, occ_clr, fill_inc, fill_dec, cnt_inc, cnt_dec;

    always_comb
    begin
        st_a = ST_MISSING; hit_a = 1'b0; ovf_a = 1'b0; fv_a = '0;
        occ_set = 1'b0; occ_clr = 1'b0; fill_inc = 1'b0; fill_dec = 1'b0;
        cnt_inc = 1'b0; cnt_dec = 1'b0;
        case (op_reg)
            OP_FIND:
            begin
                if (mfound_reg || bfound_reg)
                begin
                    st_a = ST_DONE; hit_a = 1'b1; ovf_a = !mfound_reg; fv_a = fval_reg;
                end
            end
            OP_INSERT:
            begin
                if (mfound_reg || bfound_reg)
                begin
                    st_a = ST_DONE; hit_a = 1'b1; ovf_a = !mfound_reg;
                end
                else if (free_ok_reg)
                begin
                    st_a = ST_DONE; occ_set = 1'b1; cnt_inc = 1'b1;
                end
                else if (home_fill < FILL_BITS'(BUCKET_DEPTH))
                begin
                    st_a = ST_DONE; ovf_a = 1'b1; fill_inc = 1'b1; cnt_inc = 1'b1;
                end
                else
                    st_a = ST_FULL;
            end
            OP_REMOVE:
            begin
                if (mfound_reg || bfound_reg)
                begin
                    st_a = ST_DONE; hit_a = 1'b1; ovf_a = !mfound_reg;
                    occ_clr = mfound_reg; fill_dec = !mfound_reg;
                    cnt_dec = (count_reg != '0);
                end
            end
            default:
                st_a = ST_MISSING;
        endcase
    end

    logic act;
    assign act = (state_reg == S_ACT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TABLE_SLOTS; i++)
                fill_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (act)
            begin
                out_valid_reg <= 1'b1;
                if (occ_set)
                    occ_reg[free_slot_reg] <= 1'b1;
                if (occ_clr)
                    occ_reg[mslot_reg] <= 1'b0;
                if (fill_inc)
                    fill_reg[home_reg] <= home_fill + 1'b1;
                if (fill_dec)
                    fill_reg[home_reg] <= last_idx;
                if (cnt_inc)
                    count_reg <= count_reg + 1'b1;
                if (cnt_dec)
                    count_reg <= count_reg - 1'b1;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg   <= op_t'(op);
            key_reg  <= key;
            val_reg  <= value;
            size_reg <= size_eff;
        end
        if (mrsp.done)
            home_reg <= mrsp.home;
        ptr_reg       <= ptr_next;
        pcnt_reg      <= pcnt_next;
        mfound_reg    <= mfound_next;
        mslot_reg     <= mslot_next;
        free_ok_reg   <= free_ok_next;
        free_slot_reg <= free_slot_next;
        bidx_reg      <= bidx_next;
        bfound_reg    <= bfound_next;
        bpos_reg      <= bpos_next;
        fval_reg      <= fval_next;
        if (act)
        begin
            status_reg <= st_a;
            hit_reg    <= hit_a;
            ovf_reg    <= ovf_a;
            fv_reg     <= fv_a;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign hit         = hit_reg;
    assign found_value = fv_reg;
    assign in_overflow = ovf_reg;
    assign entry_total = count_reg;

    // Checks
    `NHM_ASSERT_IMPL(a_stall_busy, clk, rst_n, out_valid, in_stall,
        "request accepted while a result is pending")
    `NHM_ASSERT_IMPL(a_hit_done, clk, rst_n, out_valid && hit, status == ST_DONE,
        "hit reported without done status")
    `NHM_ASSERT_NEXT(a_fill_bound, clk, rst_n, act && fill_inc,
        fill_reg[home_reg] <= FILL_BITS'(BUCKET_DEPTH), "bucket fill past depth")
    `NHM_ASSERT_IMPL(a_full_clean, clk, rst_n, out_valid && status == ST_FULL,
        !hit && !in_overflow, "full status with hit or overflow flag")

endmodule

/* dv/tb.sv */
// Self-checking testbench for the neighbourhood-probing hash map unit
`timescale 1ns / 1ps

module tb
    import nhm_pkg::*;
();

    localparam int N_RANDOM = 600;
    localparam int MAX_MISMATCH_PRINT = 10;

    typedef struct packed {
        logic [1:0]           status;
        logic                 hit;
        logic [WORD_BITS-1:0] found_value;
        logic                 in_overflow;
        logic [COUNT_BITS-1:0] entry_total;
    } map_rsp_t;

    typedef struct {
        logic [1:0]           op;
        logic [WORD_BITS-1:0] key;
        logic [WORD_BITS-1:0] value;
        logic [HASH_BITS-1:0] hash;
        logic                 has_rsp;
        map_rsp_t             rsp;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [SIZE_BITS-1:0]  cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            op = '0;
    logic [WORD_BITS-1:0]  key = '0;
    logic [WORD_BITS-1:0]  value = '0;
    logic [HASH_BITS-1:0]  hash_code = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [1:0]            status;
    logic                  hit;
    logic [WORD_BITS-1:0]  found_value;
    logic                  in_overflow;
    logic [COUNT_BITS-1:0] entry_total;

    // Shadow copy of the table
    logic [SIZE_BITS-1:0]  shadow_size;
    logic                  sh_occ [TABLE_SLOTS];
    logic [WORD_BITS-1:0]  sh_key [TABLE_SLOTS];
    logic [WORD_BITS-1:0]  sh_val [TABLE_SLOTS];
    logic [WORD_BITS-1:0]  sh_bkey [TABLE_SLOTS*BUCKET_DEPTH];
    logic [WORD_BITS-1:0]  sh_bval [TABLE_SLOTS*BUCKET_DEPTH];
    int                    sh_fill [TABLE_SLOTS];
    int                    sh_count;

    map_rsp_t pending_rsp[$];
    int       mismatches = 0;
    bit       calm = 1'b0;

    neighbourhood_hash_map_with_overflow_unit u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .op(op), .key(key),
        .value(value), .hash_code(hash_code), .out_valid(out_valid),
        .out_stall(out_stall), .status(status), .hit(hit),
        .found_value(found_value), .in_overflow(in_overflow),
        .entry_total(entry_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic void table_clear();
        shadow_size = SIZE_RESET;
        sh_count = 0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            sh_occ[i] = 1'b0;
            sh_fill[i] = 0;
        end
    endfunction

    // Apply one request to the shadow table and return its response
    function automatic map_rsp_t table_apply(logic [1:0] rop, logic [WORD_BITS-1:0] rkey,
                                             logic [WORD_BITS-1:0] rval,
                                             logic [HASH_BITS-1:0] rhash);
        map_rsp_t r;
        int sz, home, p, ms, bs, free_slot, base, last;
        sz = shadow_size;
        if (sz < SIZE_FLOOR) sz = SIZE_FLOOR;
        if (sz > TABLE_SLOTS) sz = TABLE_SLOTS;
        home = rhash % sz;
        base = home * BUCKET_DEPTH;
        r = '0;
        r.status = ST_MISSING;
        ms = -1;
        bs = -1;
        free_slot = -1;
        if (rop != OP_NONE)
        begin
            p = home;
            for (int n = 0; n < PROBES; n++)
            begin
                if (ms < 0 && sh_occ[p] && sh_key[p] == rkey) ms = p;
                if (free_slot < 0 && !sh_occ[p]) free_slot = p;
                p = (p + 1) % sz;
            end
            if (ms < 0)
                for (int i = 0; i < sh_fill[home]; i++)
                    if (bs < 0 && sh_bkey[base+i] == rkey) bs = i;
        end
        case (rop)
            OP_FIND:
            begin
                if (ms >= 0)
                begin
                    r.status = ST_DONE; r.hit = 1'b1; r.found_value = sh_val[ms];
                end
                else if (bs >= 0)
                begin
                    r.status = ST_DONE; r.hit = 1'b1; r.in_overflow = 1'b1;
                    r.found_value = sh_bval[base+bs];
                end
            end
            OP_INSERT:
            begin
                r.status = ST_DONE;
                if (ms >= 0)
                begin
                    sh_val[ms] = rval; r.hit = 1'b1;
                end
                else if (bs >= 0)
                begin
                    sh_bval[base+bs] = rval; r.hit = 1'b1; r.in_overflow = 1'b1;
                end
                else if (free_slot >= 0)
                begin
                    sh_occ[free_slot] = 1'b1;
                    sh_key[free_slot] = rkey;
                    sh_val[free_slot] = rval;
                    sh_count++;
                end
                else if (sh_fill[home] < BUCKET_DEPTH)
                begin
                    sh_bkey[base+sh_fill[home]] = rkey;
                    sh_bval[base+sh_fill[home]] = rval;
                    sh_fill[home]++;
                    sh_count++;
                    r.in_overflow = 1'b1;
                end
                else
                    r.status = ST_FULL;
            end
            OP_REMOVE:
            begin
                if (ms >= 0)
                begin
                    sh_occ[ms] = 1'b0;
                    if (sh_count > 0) sh_count--;
                    r.status = ST_DONE; r.hit = 1'b1;
                end
                else if (bs >= 0)
                begin
                    last = sh_fill[home] - 1;
                    sh_bkey[base+bs] = sh_bkey[base+last];
                    sh_bval[base+bs] = sh_bval[base+last];
                    sh_fill[home] = last;
                    if (sh_count > 0) sh_count--;
                    r.status = ST_DONE; r.hit = 1'b1; r.in_overflow = 1'b1;
                end
            end
            default: ;
        endcase
        r.entry_total = sh_count[COUNT_BITS-1:0];
        return r;
    endfunction

    // Send one request; optionally check the predictor against a typed-in response
    task automatic send_request(logic [1:0] rop, logic [WORD_BITS-1:0] rkey,
                                logic [WORD_BITS-1:0] rval, logic [HASH_BITS-1:0] rhash,
                                bit has_rsp, map_rsp_t known);
        map_rsp_t pred;
        while (!calm && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        pred = table_apply(rop, rkey, rval, rhash);
        if (has_rsp && pred !== known)
        begin
            mismatches++;
            if (mismatches <= MAX_MISMATCH_PRINT)
                $display("directed row disagrees: table %h typed %h", pred, known);
        end
        pending_rsp.push_back(pred);
        in_valid  <= 1'b1;
        op        <= rop;
        key       <= rkey;
        value     <= rval;
        hash_code <= rhash;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Write the size register once every response has drained
    task automatic set_size(logic [SIZE_BITS-1:0] sz);
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= sz;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_size = sz;
    endtask

    // Output side: random stall and compare
    always @(posedge clk)
    begin
        map_rsp_t got, exp_rsp;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{status, hit, found_value, in_overflow, entry_total};
                if (pending_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_MISMATCH_PRINT)
                        $display("unexpected response %h", got);
                end
                else
                begin
                    exp_rsp = pending_rsp.pop_front();
                    if (got !== exp_rsp)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_MISMATCH_PRINT)
                            $display("response mismatch: expected %h actual %h",
                                     exp_rsp, got);
                    end
                end
            end
            out_stall <= !calm && ($urandom_range(99) < 32);
        end
    end

    initial
    begin
        dir_row_t rows[$];
        map_rsp_t none;
        logic [1:0] rop;
        logic [WORD_BITS-1:0] rkey;
        logic [HASH_BITS-1:0] rh;
        int steps;
        logic [SIZE_BITS-1:0] sizes[6];

        none = '0;
        table_clear();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: miss after reset, extremes, overflow fill, full, unused op
        rows.push_back('{OP_FIND, 32'h0, 32'h0, 32'h0, 1'b1,
                         '{ST_MISSING, 1'b0, 32'h0, 1'b0, 9'd0}});
        rows.push_back('{OP_REMOVE, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 1'b1,
                         '{ST_MISSING, 1'b0, 32'h0, 1'b0, 9'd0}});
        rows.push_back('{OP_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
                         '{ST_DONE, 1'b0, 32'h0, 1'b0, 9'd1}});
        rows.push_back('{OP_FIND, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 1'b1,
                         '{ST_DONE, 1'b1, 32'hFFFFFFFF, 1'b0, 9'd1}});
        rows.push_back('{OP_NONE, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 1'b1,
                         '{ST_MISSING, 1'b0, 32'h0, 1'b0, 9'd1}});
        // Nine keys on one home: four slots, four bucket entries, then full
        for (int i = 0; i < 9; i++)
            rows.push_back('{OP_INSERT, 32'h100 + i, 32'hA0 + i, 32'd7, 1'b0, none});
        rows.push_back('{OP_FIND, 32'h106, 32'h0, 32'd7, 1'b0, none});
        rows.push_back('{OP_INSERT, 32'h105, 32'h55, 32'd7, 1'b0, none});
        rows.push_back('{OP_REMOVE, 32'h104, 32'h0, 32'd7, 1'b0, none});
        rows.push_back('{OP_FIND, 32'h107, 32'h0, 32'd7, 1'b0, none});
        rows.push_back('{OP_REMOVE, 32'h101, 32'h0, 32'd7, 1'b0, none});
        rows.push_back('{OP_INSERT, 32'h0, 32'h0, 32'd52, 1'b0, none});
        rows.push_back('{OP_INSERT, 32'h1, 32'h1, 32'd52, 1'b0, none});
        rows.push_back('{OP_FIND, 32'h1, 32'h0, 32'd52, 1'b0, none});
        foreach (rows[i])
            send_request(rows[i].op, rows[i].key, rows[i].value, rows[i].hash,
                         rows[i].has_rsp, rows[i].rsp);

        // Random phases across size settings, out-of-range values included
        sizes = '{7'd0, 7'd4, 7'd64, 7'd127, 7'd5, 7'd37};
        for (int ph = 0; ph < 6; ph++)
        begin
            set_size(sizes[ph]);
            calm = (ph == 2);
            steps = N_RANDOM / 6;
            for (int n = 0; n < steps; n++)
            begin
                rop = $urandom_range(99) < 4 ? OP_NONE : 2'($urandom_range(2));
                if ($urandom_range(9) < 8)
                begin
                    // Small key pool on few homes to exercise collisions and buckets
                    rkey = $urandom_range(23);
                    rh = (rkey % 6) + ($urandom_range(1) ? 32'hFFFFFF00 : 32'h0);
                end
                else
                begin
                    rkey = $urandom;
                    rh = $urandom;
                end
                send_request(rop, rkey, $urandom, rh, 1'b0, none);
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        steps = 0;
        while (pending_rsp.size() != 0 && steps < 100000)
        begin
            @(posedge clk);
            steps++;
        end
        repeat (60) @(posedge clk);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+hdl
hdl/nhm_pkg.sv
hdl/nhm_mod.sv
hdl/neighbourhood_hash_map_with_overflow_unit.sv
dv/tb.sv
